>>> hw/rtl/chsc_pkg.sv
// ---------------------------------------------------------------------------
// chsc_pkg: shared types and constants for the clock hand stepper controller
// Beat payloads, configuration set, event codes and reset values.
// ---------------------------------------------------------------------------
package chsc_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_RUN_ENABLED      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ERROR_STEP_LIMIT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_GAP_STEPS    = 2'd2;

    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_SAMPLE = 2'd1;
    localparam logic [1:0] MODE_HOME   = 2'd2;
    localparam logic [1:0] MODE_COUNT  = 2'd3;

    localparam logic [15:0] LIMIT_RESET   = 16'd1500;
    localparam logic [15:0] MIN_GAP_RESET = 16'd100;

    typedef struct packed {
        logic [1:0] mode;
        logic       minute_sensor;
        logic       hour_sensor;
        logic [4:0] real_hour;
        logic [5:0] real_minute;
    } in_t;

    typedef struct packed {
        logic        step_request;
        logic        direction;
        logic        driver_enable;
        logic        sensor_led;
        logic [2:0]  status;
        logic [3:0]  dial_hour;
        logic [5:0]  dial_minute;
        logic [15:0] revolution_steps;
    } out_t;

    typedef struct packed {
        logic        run_enabled;
        logic [15:0] error_step_limit;
        logic [15:0] min_gap_steps;
    } cfg_t;

endpackage

>>> hw/rtl/chsc_core.sv
// ---------------------------------------------------------------------------
// chsc_core: event processor for the clock hand stepper controller
// Holds the dial state and works out one result per event in a single pass.
// ---------------------------------------------------------------------------
module chsc_core
    import chsc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic fire,
    input  in_t  item,
    input  cfg_t cfg,
    output out_t result
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_HOMING   = 7'b0000010,
        S_COUNTING = 7'b0000100,
        S_WORKING  = 7'b0001000,
        S_HOUR     = 7'b0010000,
        S_MINUTE   = 7'b0100000,
        S_ERROR    = 7'b1000000
    } state_t;

    localparam logic [2:0] STAT_IDLE     = 3'd0;
    localparam logic [2:0] STAT_HOMING   = 3'd1;
    localparam logic [2:0] STAT_COUNTING = 3'd2;
    localparam logic [2:0] STAT_WORKING  = 3'd3;
    localparam logic [2:0] STAT_HOUR     = 3'd4;
    localparam logic [2:0] STAT_MINUTE   = 3'd5;
    localparam logic [2:0] STAT_ERROR    = 3'd6;

    // floor(x/60) == (x * RECIP60) >> 18 for x below 4681
    localparam logic [18:0] RECIP60     = 19'd4370;
    localparam logic [15:0] SPT_RESET   = 16'd400;
    localparam logic [18:0] RECIP_RESET = 19'((400 % 64) * 4370);
    localparam logic [15:0] SPT_FULL    = 16'd60;

    state_t      state_reg,  state_next;
    logic [19:0] count_reg,  count_next;
    logic [3:0]  dh_reg,     dh_next;
    logic [5:0]  dm_reg,     dm_next;
    logic [3:0]  th_reg,     th_next;
    logic [5:0]  tm_reg,     tm_next;
    logic [15:0] spt_reg,    spt_next;
    logic [18:0] recip_reg,  recip_next;
    logic        dir_reg,    dir_next;
    logic        drv_reg,    drv_next;
    logic        led_reg,    led_next;
    logic        step;

    logic [3:0]  th_in;
    logic [3:0]  eff_th;
    logic [5:0]  eff_tm;
    logic        sample_act;
    logic        s_skip;
    logic        hour_call;
    logic        hour_roll;
    logic        minute_call;
    logic [3:0]  new_dh;
    logic [5:0]  min_b;
    logic [3:0]  min_bh;
    logic [6:0]  min_inc;
    logic [24:0] frac_a;
    logic [24:0] frac_b;
    logic        want_gt;
    logic [19:0] limit20;
    logic [19:0] limit12;

    function automatic logic [2:0] status_of(input state_t s);
        logic [2:0] code;
        unique case (s)
            S_IDLE:     code = STAT_IDLE;
            S_HOMING:   code = STAT_HOMING;
            S_COUNTING: code = STAT_COUNTING;
            S_WORKING:  code = STAT_WORKING;
            S_HOUR:     code = STAT_HOUR;
            S_MINUTE:   code = STAT_MINUTE;
            S_ERROR:    code = STAT_ERROR;
            default:    code = STAT_IDLE;
        endcase
        return code;
    endfunction

    always_comb
    begin
        if (item.real_hour >= 5'd24)
        begin
            th_in = 4'(item.real_hour - 5'd24);
        end
        else if (item.real_hour >= 5'd12)
        begin
            th_in = 4'(item.real_hour - 5'd12);
        end
        else
        begin
            th_in = item.real_hour[3:0];
        end
    end

    assign limit20 = {4'b0, cfg.error_step_limit};
    assign limit12 = (limit20 << 3) + (limit20 << 2);

    assign sample_act = (item.mode == MODE_SAMPLE) && (state_reg == S_WORKING);
    assign eff_th     = sample_act ? th_in : th_reg;
    assign eff_tm     = sample_act ? item.real_minute : tm_reg;

    assign s_skip = (dh_reg == th_in) &&
                    (({1'b0, dm_reg} == {1'b0, item.real_minute}) ||
                     ({1'b0, dm_reg} == {1'b0, item.real_minute} + 7'd1) ||
                     ({1'b0, item.real_minute} == {1'b0, dm_reg} + 7'd1));

    assign new_dh = (dh_reg >= 4'd11) ? 4'd0 : dh_reg + 4'd1;

    assign hour_call = (sample_act && !s_skip && (dh_reg < th_in)) ||
                       ((item.mode == MODE_TICK) && (state_reg == S_HOUR));
    assign hour_roll = hour_call && !item.minute_sensor && (count_reg > 20'd5);

    assign minute_call = (sample_act && !s_skip && (dh_reg == th_in)) ||
                         ((item.mode == MODE_TICK) && (state_reg == S_MINUTE)) ||
                         (hour_roll && (new_dh == eff_th));

    assign min_b   = hour_roll ? 6'd0 : dm_reg;
    assign min_bh  = hour_roll ? new_dh : dh_reg;
    assign min_inc = {1'b0, min_b} + 7'd1;

    // dial position in steps rises with the minute; only short turns can tie
    assign frac_a  = {19'b0, eff_tm} * {6'b0, recip_reg};
    assign frac_b  = {19'b0, min_b} * {6'b0, recip_reg};
    assign want_gt = (eff_tm > min_b) &&
                     ((spt_reg >= SPT_FULL) || (frac_a[24:18] > frac_b[24:18]));

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        dh_next    = dh_reg;
        dm_next    = dm_reg;
        th_next    = th_reg;
        tm_next    = tm_reg;
        spt_next   = spt_reg;
        recip_next = recip_reg;
        dir_next   = dir_reg;
        drv_next   = drv_reg;
        led_next   = led_reg;
        step       = 1'b0;

        unique case (item.mode)
            MODE_HOME:
            begin
                state_next = S_HOMING;
                led_next   = 1'b1;
                drv_next   = 1'b1;
                dir_next   = 1'b1;
                count_next = '0;
                step       = 1'b1;
            end
            MODE_COUNT:
            begin
                dir_next   = 1'b0;
                count_next = '0;
                if (cfg.error_step_limit == 16'd0)
                begin
                    state_next = S_ERROR;
                    drv_next   = 1'b0;
                    led_next   = 1'b0;
                end
                else
                begin
                    state_next = S_COUNTING;
                    led_next   = 1'b1;
                    drv_next   = 1'b1;
                    count_next = 20'd1;
                    step       = 1'b1;
                end
            end
            MODE_SAMPLE:
            begin
                if (sample_act)
                begin
                    th_next = th_in;
                    tm_next = item.real_minute;
                    if (!s_skip && (dh_reg > th_in))
                    begin
                        state_next = S_HOMING;
                        led_next   = 1'b1;
                        drv_next   = 1'b1;
                        dir_next   = 1'b1;
                        count_next = '0;
                        step       = 1'b1;
                    end
                end
            end
            MODE_TICK:
            begin
                if (state_reg == S_HOMING)
                begin
                    if (count_reg > limit12)
                    begin
                        state_next = S_ERROR;
                        count_next = '0;
                        drv_next   = 1'b0;
                        led_next   = 1'b0;
                    end
                    else if (item.minute_sensor && item.hour_sensor)
                    begin
                        dh_next    = '0;
                        dm_next    = '0;
                        count_next = '0;
                        drv_next   = 1'b0;
                        led_next   = 1'b0;
                        state_next = cfg.run_enabled ? S_WORKING : S_IDLE;
                    end
                    else
                    begin
                        count_next = count_reg + 20'd1;
                        step       = 1'b1;
                    end
                end
                else if (state_reg == S_COUNTING)
                begin
                    if (count_reg >= limit20)
                    begin
                        state_next = S_ERROR;
                        count_next = '0;
                        drv_next   = 1'b0;
                        led_next   = 1'b0;
                    end
                    else if (item.minute_sensor && (count_reg > {4'b0, cfg.min_gap_steps}))
                    begin
                        spt_next   = count_reg[15:0];
                        recip_next = 19'({13'b0, count_reg[5:0]} * RECIP60);
                        count_next = '0;
                        drv_next   = 1'b0;
                        led_next   = 1'b0;
                        state_next = cfg.run_enabled ? S_WORKING : S_IDLE;
                    end
                    else
                    begin
                        count_next = count_reg + 20'd1;
                        step       = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (hour_call)
        begin
            led_next = 1'b1;
            drv_next = 1'b1;
            dir_next = 1'b0;
            if (!hour_roll)
            begin
                if (count_reg < limit20)
                begin
                    state_next = S_HOUR;
                    count_next = count_reg + 20'd1;
                    step       = 1'b1;
                end
                else
                begin
                    state_next = S_ERROR;
                    drv_next   = 1'b0;
                    led_next   = 1'b0;
                end
            end
            else
            begin
                dh_next    = new_dh;
                dm_next    = '0;
                count_next = '0;
                led_next   = 1'b0;
                if (new_dh > eff_th)
                begin
                    state_next = S_HOMING;
                    led_next   = 1'b1;
                    drv_next   = 1'b1;
                    dir_next   = 1'b1;
                    step       = 1'b1;
                end
                else if (new_dh < eff_th)
                begin
                    led_next = 1'b1;
                    if (cfg.error_step_limit != 16'd0)
                    begin
                        state_next = S_HOUR;
                        count_next = 20'd1;
                        step       = 1'b1;
                    end
                    else
                    begin
                        state_next = S_ERROR;
                        drv_next   = 1'b0;
                        led_next   = 1'b0;
                    end
                end
            end
        end

        if (minute_call)
        begin
            if (want_gt)
            begin
                state_next = S_MINUTE;
                drv_next   = 1'b1;
                dir_next   = 1'b0;
                step       = 1'b1;
                if (min_inc >= 7'd60)
                begin
                    dm_next = '0;
                    dh_next = (min_bh >= 4'd11) ? 4'd0 : min_bh + 4'd1;
                end
                else
                begin
                    dm_next = min_inc[5:0];
                    dh_next = min_bh;
                end
            end
            else
            begin
                drv_next   = 1'b0;
                state_next = S_WORKING;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            dh_reg    <= '0;
            dm_reg    <= '0;
            th_reg    <= '0;
            tm_reg    <= '0;
            spt_reg   <= SPT_RESET;
            recip_reg <= RECIP_RESET;
            dir_reg   <= 1'b0;
            drv_reg   <= 1'b0;
            led_reg   <= 1'b0;
        end
        else if (fire)
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            dh_reg    <= dh_next;
            dm_reg    <= dm_next;
            th_reg    <= th_next;
            tm_reg    <= tm_next;
            spt_reg   <= spt_next;
            recip_reg <= recip_next;
            dir_reg   <= dir_next;
            drv_reg   <= drv_next;
            led_reg   <= led_next;
        end
    end

    always_comb
    begin
        result.step_request     = step;
        result.direction        = dir_next;
        result.driver_enable    = drv_next;
        result.sensor_led       = led_next;
        result.status           = status_of(state_next);
        result.dial_hour        = dh_next;
        result.dial_minute      = dm_next;
        result.revolution_steps = spt_next;
    end

endmodule

>>> hw/rtl/clock_hand_stepper_controller_top.sv
// ---------------------------------------------------------------------------
// clock_hand_stepper_controller_top: stepper clock dial controller
// Input beat register, event processor and a two-deep result buffer.
// ---------------------------------------------------------------------------
// Usage
//   in_valid/in_stall/in_data carry events (step tick, time sample, start
//   homing, start counting). Each event gives exactly one result beat on
//   out_valid/out_stall/out_data: step request, drive outputs, status, dial
//   position and steps per revolution.
//   Timing: an event beat taken sits in the input register; its result
//   beat is computed from there and held in the result register, from
//   which it is offered. Throughput: one event per cycle while the skid
//   entry is empty, set by the single-pass event processor.
//   Stalls: the result register has a skid entry behind it, so the block
//   keeps taking events while a result waits; in_stall rises only once the
//   skid entry is full and the input register is occupied.
//   Configuration (cfg_write/cfg_index/cfg_data) is for the user to write while
//   idle; the block does not enforce this. Unknown indexes are dropped.
//   Reset: asynchronous, active low; all state returns to idle with the dial
//   at 0:00, 400 steps per turn, driver and light off, buffers empty.
// ---------------------------------------------------------------------------
module clock_hand_stepper_controller_top
    import chsc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_t                    in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_t                   out_data,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t cfg_reg;
    logic in_valid_reg;
    in_t  in_data_reg;
    logic out_valid_reg;
    out_t out_data_reg;
    logic skid_valid_reg;
    out_t skid_data_reg;
    out_t result;
    logic in_take;
    logic fire;
    logic out_pop;
    logic to_skid;

    assign in_stall = in_valid_reg && skid_valid_reg;
    assign in_take  = in_valid && !in_stall;
    assign fire     = in_valid_reg && !skid_valid_reg;
    assign out_pop  = out_valid_reg && !out_stall;
    assign to_skid  = fire && out_valid_reg && !out_pop;

    chsc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (in_data_reg),
        .cfg    (cfg_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.run_enabled      <= 1'b0;
            cfg_reg.error_step_limit <= LIMIT_RESET;
            cfg_reg.min_gap_steps    <= MIN_GAP_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_RUN_ENABLED:      cfg_reg.run_enabled      <= cfg_data[0];
                CFG_ERROR_STEP_LIMIT: cfg_reg.error_step_limit <= cfg_data;
                CFG_MIN_GAP_STEPS:    cfg_reg.min_gap_steps    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end

            if (skid_valid_reg)
            begin
                if (out_pop)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (to_skid)
            begin
                skid_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_data_reg <= in_data;
        end
        if (skid_valid_reg && out_pop)
        begin
            out_data_reg <= skid_data_reg;
        end
        else if (fire && !to_skid)
        begin
            out_data_reg <= result;
        end
        if (to_skid)
        begin
            skid_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> tb/clock_hand_stepper_controller_top_tb.sv
// ---------------------------------------------------------------------------
// clock_hand_stepper_controller_top_tb: dial controller event/result checker
// A short table of directed events (reset state, zero and full limits,
// homing, counting, hour and minute advance), then phases of random event
// sequences under varied register values. Every result beat is checked
// field by field against the table's result where given, else an in-bench
// model of the dial, with random sender bursts and receiver stalls.
// ---------------------------------------------------------------------------
module clock_hand_stepper_controller_top_tb;
    import chsc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_HOMING, ST_COUNTING, ST_WORKING, ST_HOUR, ST_MINUTE, ST_ERROR
    } dial_state_e;

    localparam logic [15:0]            TURN_RESET = 16'd400;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic        is_cfg;
        logic        run;
        logic [15:0] lim;
        logic [15:0] gap;
        in_t         beat;
        logic        typed;
        out_t        want;
    } row_t;

    typedef struct packed {
        logic        run;
        logic [15:0] lim;
        logic [15:0] gap;
    } regime_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    in_t                    in_data   = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    out_t                   out_data;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_RUN_ENABLED;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    clock_hand_stepper_controller_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // dial model
    logic        m_run;
    logic [15:0] m_limit;
    logic [15:0] m_gap;
    dial_state_e m_state;
    logic [19:0] m_count;
    logic [3:0]  m_hour;
    logic [5:0]  m_minute;
    logic [3:0]  m_target_hour;
    logic [5:0]  m_target_minute;
    logic [15:0] m_turn;
    logic        m_ccw;
    logic        m_drive;
    logic        m_led;
    logic        m_pulse;

    out_t readouts_due[$];
    int   errors      = 0;
    int   readout_idx = 0;
    int   burst_left  = 0;
    int   stall_style = 0;
    int   stall_left  = 0;
    out_t due;

    row_t    plan [27];
    regime_t regimes [10];

    function automatic void settle_run(input logic ok);
        m_count = '0;
        m_drive = 1'b0;
        m_led   = 1'b0;
        m_state = !ok ? ST_ERROR : (m_run ? ST_WORKING : ST_IDLE);
    endfunction

    function automatic void start_home();
        m_state = ST_HOMING;
        m_led   = 1'b1;
        m_drive = 1'b1;
        m_ccw   = 1'b1;
        m_count = '0;
        m_pulse = 1'b1;
    endfunction

    function automatic void count_tick(input logic ms);
        if (m_count >= 20'(m_limit))
            settle_run(1'b0);
        else if (ms && m_count > 20'(m_gap))
        begin
            m_turn = m_count[15:0];
            settle_run(1'b1);
        end
        else
        begin
            m_count = m_count + 20'd1;
            m_pulse = 1'b1;
        end
    endfunction

    function automatic void minute_move();
        int unsigned want_pos;
        int unsigned have_pos;
        want_pos = 32'(m_target_minute) * 32'(m_turn) / 32'd60;
        have_pos = 32'(m_minute) * 32'(m_turn) / 32'd60;
        if (want_pos > have_pos)
        begin
            m_state = ST_MINUTE;
            m_drive = 1'b1;
            m_ccw   = 1'b0;
            if (m_minute >= 6'd59)
            begin
                m_minute = '0;
                m_hour   = (m_hour >= 4'd11) ? 4'd0 : m_hour + 4'd1;
            end
            else
                m_minute = m_minute + 6'd1;
            m_pulse = 1'b1;
        end
        else
        begin
            m_drive = 1'b0;
            m_state = ST_WORKING;
        end
    endfunction

    function automatic void hour_push();
        if (m_count < 20'(m_limit))
        begin
            m_state = ST_HOUR;
            m_count = m_count + 20'd1;
            m_pulse = 1'b1;
        end
        else
        begin
            m_state = ST_ERROR;
            m_drive = 1'b0;
            m_led   = 1'b0;
        end
    endfunction

    function automatic void hour_move(input logic ms);
        m_led   = 1'b1;
        m_drive = 1'b1;
        m_ccw   = 1'b0;
        if (ms || m_count <= 20'd5)
            hour_push();
        else
        begin
            m_hour   = (m_hour >= 4'd11) ? 4'd0 : m_hour + 4'd1;
            m_minute = '0;
            m_count  = '0;
            m_led    = 1'b0;
            if (m_hour == m_target_hour)
                minute_move();
            else if (m_hour > m_target_hour)
                start_home();
            else
            begin
                m_led = 1'b1;
                hour_push();
            end
        end
    endfunction

    function automatic out_t dial_predict(input in_t b);
        logic [5:0] spread;
        m_pulse = 1'b0;
        case (b.mode)
            MODE_HOME:
                start_home();
            MODE_COUNT:
            begin
                m_state = ST_COUNTING;
                m_led   = 1'b1;
                m_drive = 1'b1;
                m_ccw   = 1'b0;
                m_count = '0;
                count_tick(b.minute_sensor);
            end
            MODE_SAMPLE:
            begin
                if (m_state == ST_WORKING)
                begin
                    m_target_hour   = 4'(b.real_hour % 5'd12);
                    m_target_minute = b.real_minute;
                    spread = (m_minute > m_target_minute) ? m_minute - m_target_minute
                                                          : m_target_minute - m_minute;
                    if (!(m_hour == m_target_hour && spread <= 6'd1))
                    begin
                        if (m_hour > m_target_hour)
                            start_home();
                        else if (m_hour < m_target_hour)
                            hour_move(b.minute_sensor);
                        else
                            minute_move();
                    end
                end
            end
            default:
            begin
                case (m_state)
                    ST_HOMING:
                    begin
                        if (32'(m_count) > 32'(m_limit) * 32'd12)
                            settle_run(1'b0);
                        else if (b.minute_sensor && b.hour_sensor)
                        begin
                            m_hour   = '0;
                            m_minute = '0;
                            settle_run(1'b1);
                        end
                        else
                        begin
                            m_count = m_count + 20'd1;
                            m_pulse = 1'b1;
                        end
                    end
                    ST_COUNTING: count_tick(b.minute_sensor);
                    ST_HOUR:     hour_move(b.minute_sensor);
                    ST_MINUTE:   minute_move();
                    default:     ;
                endcase
            end
        endcase
        return out_t'{m_pulse, m_ccw, m_drive, m_led, m_state, m_hour, m_minute, m_turn};
    endfunction

    function automatic row_t ev(input logic [1:0] mode, input logic ms, input logic hs,
                                input logic [4:0] rh, input logic [5:0] rm);
        row_t r;
        r      = '0;
        r.beat = in_t'{mode, ms, hs, rh, rm};
        return r;
    endfunction

    function automatic row_t known(input row_t r, input out_t w);
        row_t k;
        k       = r;
        k.typed = 1'b1;
        k.want  = w;
        return k;
    endfunction

    function automatic out_t shows(input logic step, input logic dir, input logic drv,
                                   input logic led, input dial_state_e s);
        return out_t'{step, dir, drv, led, s, 4'd0, 6'd0, TURN_RESET};
    endfunction

    function automatic row_t regs(input logic run, input logic [15:0] lim,
                                  input logic [15:0] gap);
        row_t r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.run    = run;
        r.lim    = lim;
        r.gap    = gap;
        return r;
    endfunction

    task automatic send(input in_t b, input logic typed, input out_t want);
        out_t model_out;
        in_data  <= b;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        model_out = dial_predict(b);
        readouts_due.push_back(typed ? want : model_out);
    endtask

    task automatic pace();
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8))
                @(posedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(0, 12);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (readouts_due.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic set_regs(input logic run, input logic [15:0] lim, input logic [15:0] gap);
        cfg_write <= 1'b1;
        cfg_index <= CFG_UNUSED;
        cfg_data  <= 16'($urandom);
        @(posedge clk);
        cfg_index <= CFG_RUN_ENABLED;
        cfg_data  <= {15'd0, run};
        @(posedge clk);
        cfg_index <= CFG_ERROR_STEP_LIMIT;
        cfg_data  <= lim;
        @(posedge clk);
        cfg_index <= CFG_MIN_GAP_STEPS;
        cfg_data  <= gap;
        @(posedge clk);
        cfg_write <= 1'b0;
        m_run   = run;
        m_limit = lim;
        m_gap   = gap;
    endtask

    // result beats: check, then pick the next stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                readout_idx++;
                if (readouts_due.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("result beat %0d arrived with nothing expected", readout_idx);
                end
                else
                begin
                    due = readouts_due.pop_front();
                    if (out_data.step_request     !== due.step_request  ||
                        out_data.direction        !== due.direction     ||
                        out_data.driver_enable    !== due.driver_enable ||
                        out_data.sensor_led       !== due.sensor_led    ||
                        out_data.status           !== due.status        ||
                        out_data.dial_hour        !== due.dial_hour     ||
                        out_data.dial_minute      !== due.dial_minute   ||
                        out_data.revolution_steps !== due.revolution_steps)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("beat %0d: exp step %b dir %b drv %b led %b st %0d ",
                                     readout_idx, due.step_request, due.direction,
                                     due.driver_enable, due.sensor_led, due.status,
                                     "%0d:%0d turn %0d", due.dial_hour, due.dial_minute,
                                     due.revolution_steps,
                                     " / got step %b dir %b drv %b led %b st %0d ",
                                     out_data.step_request, out_data.direction,
                                     out_data.driver_enable, out_data.sensor_led,
                                     out_data.status,
                                     "%0d:%0d turn %0d", out_data.dial_hour,
                                     out_data.dial_minute, out_data.revolution_steps);
                    end
                end
            end
            if (stall_left == 0)
            begin
                stall_style = $urandom_range(0, 3);
                stall_left  = $urandom_range(20, 200);
            end
            stall_left--;
            case (stall_style)
                0:       out_stall <= 1'b0;
                1:       out_stall <= 1'($urandom_range(0, 1));
                2:       out_stall <= ($urandom_range(0, 7) == 0);
                default: out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        in_t b;
        int  roll;
        int  counted;

        m_run           = 1'b0;
        m_limit         = LIMIT_RESET;
        m_gap           = MIN_GAP_RESET;
        m_state         = ST_IDLE;
        m_count         = '0;
        m_hour          = '0;
        m_minute        = '0;
        m_target_hour   = '0;
        m_target_minute = '0;
        m_turn          = TURN_RESET;
        m_ccw           = 1'b0;
        m_drive         = 1'b0;
        m_led           = 1'b0;
        m_pulse         = 1'b0;

        plan = '{
            known(ev(MODE_TICK,   1'b0, 1'b0, 5'd0,  6'd0),  shows(0, 0, 0, 0, ST_IDLE)),
            known(ev(MODE_SAMPLE, 1'b1, 1'b1, 5'd31, 6'd63), shows(0, 0, 0, 0, ST_IDLE)),
            known(ev(MODE_HOME,   1'b0, 1'b0, 5'd0,  6'd0),  shows(1, 1, 1, 1, ST_HOMING)),
            known(ev(MODE_TICK,   1'b1, 1'b1, 5'd0,  6'd0),  shows(0, 1, 0, 0, ST_IDLE)),
            regs(1'b1, 16'd0, 16'd0),
            known(ev(MODE_COUNT,  1'b1, 1'b0, 5'd0,  6'd0),  shows(0, 0, 0, 0, ST_ERROR)),
            known(ev(MODE_HOME,   1'b0, 1'b0, 5'd0,  6'd0),  shows(1, 1, 1, 1, ST_HOMING)),
            ev(MODE_TICK,   1'b0, 1'b1, 5'd0,  6'd0),
            known(ev(MODE_TICK,   1'b1, 1'b0, 5'd0,  6'd0),  shows(0, 1, 0, 0, ST_ERROR)),
            regs(1'b1, 16'hFFFF, 16'd0),
            known(ev(MODE_HOME,   1'b0, 1'b0, 5'd0,  6'd0),  shows(1, 1, 1, 1, ST_HOMING)),
            known(ev(MODE_TICK,   1'b1, 1'b1, 5'd0,  6'd0),  shows(0, 1, 0, 0, ST_WORKING)),
            known(ev(MODE_SAMPLE, 1'b0, 1'b0, 5'd0,  6'd1),  shows(0, 1, 0, 0, ST_WORKING)),
            ev(MODE_SAMPLE, 1'b0, 1'b0, 5'd12, 6'd3),
            ev(MODE_TICK,   1'b0, 1'b0, 5'd0,  6'd0),
            ev(MODE_TICK,   1'b1, 1'b1, 5'd0,  6'd0),
            ev(MODE_TICK,   1'b1, 1'b0, 5'd0,  6'd0),
            ev(MODE_SAMPLE, 1'b1, 1'b0, 5'd24, 6'd0),
            ev(MODE_SAMPLE, 1'b0, 1'b0, 5'd13, 6'd0),
            ev(MODE_TICK,   1'b1, 1'b0, 5'd0,  6'd0),
            ev(MODE_TICK,   1'b1, 1'b1, 5'd0,  6'd0),
            ev(MODE_TICK,   1'b1, 1'b0, 5'd0,  6'd0),
            ev(MODE_TICK,   1'b1, 1'b0, 5'd0,  6'd0),
            ev(MODE_TICK,   1'b1, 1'b0, 5'd0,  6'd0),
            ev(MODE_TICK,   1'b0, 1'b0, 5'd0,  6'd0),
            ev(MODE_COUNT,  1'b0, 1'b0, 5'd0,  6'd0),
            ev(MODE_TICK,   1'b1, 1'b0, 5'd0,  6'd0)
        };

        regimes = '{
            regime_t'{1'b1, 16'd30,    16'd4},
            regime_t'{1'b1, 16'd12,    16'd0},
            regime_t'{1'b0, 16'd8,     16'd2},
            regime_t'{1'b1, 16'hFFFF,  16'hFFFF},
            regime_t'{1'b1, 16'd3,     16'd1},
            regime_t'{1'b1, 16'd0,     16'd0},
            regime_t'{1'b1, 16'hFFFF,  16'd0},
            regime_t'{1'b1, 16'd20,    16'd7},
            regime_t'{1'b0, 16'hFFFF,  16'd5},
            regime_t'{1'b1, 16'd50,    16'd12}
        };

        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                drain();
                set_regs(plan[i].run, plan[i].lim, plan[i].gap);
            end
            else
            begin
                send(plan[i].beat, plan[i].typed, plan[i].want);
                pace();
            end
        end

        foreach (regimes[p])
        begin
            drain();
            set_regs(regimes[p].run, regimes[p].lim, regimes[p].gap);
            counted = 0;
            while (counted < 75)
            begin
                roll = $urandom_range(0, 99);
                b    = in_t'(15'($urandom));
                if (roll >= ((m_state == ST_COUNTING || m_state == ST_HOMING) ? 2 : 8))
                begin
                    case (m_state)
                        ST_IDLE, ST_ERROR:
                            b.mode = ($urandom_range(0, 2) != 0) ? MODE_HOME : MODE_COUNT;
                        ST_HOMING:
                        begin
                            b.mode = MODE_TICK;
                            {b.minute_sensor, b.hour_sensor} =
                                ($urandom_range(0, 7) == 0) ? 2'b11 : 2'($urandom_range(0, 2));
                        end
                        ST_COUNTING:
                        begin
                            b.mode          = MODE_TICK;
                            b.minute_sensor = (m_count > 20'(m_gap)) ?
                                              ($urandom_range(0, 3) == 0) :
                                              1'($urandom_range(0, 1));
                        end
                        ST_WORKING:
                        begin
                            b.mode = MODE_SAMPLE;
                            if ($urandom_range(0, 2) == 0)
                                b.real_hour = 5'(m_hour) +
                                              (($urandom_range(0, 1) != 0) ? 5'd12 : 5'd0);
                        end
                        ST_HOUR:
                        begin
                            b.mode          = MODE_TICK;
                            b.minute_sensor = ($urandom_range(0, 3) == 0);
                        end
                        default:
                            b.mode = MODE_TICK;
                    endcase
                end
                if (!((b.mode == MODE_TICK && (m_state == ST_IDLE || m_state == ST_WORKING ||
                                               m_state == ST_ERROR)) ||
                      (b.mode == MODE_SAMPLE && m_state != ST_WORKING)))
                    counted++;
                send(b, 1'b0, '0);
                pace();
                if ($urandom_range(0, 149) == 0)
                    drain();
            end
        end

        in_valid <= 1'b0;
        while (readouts_due.size() != 0)
            @(posedge clk);
        repeat (10)
            @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/chsc_pkg.sv
hw/rtl/chsc_core.sv
hw/rtl/clock_hand_stepper_controller_top.sv
tb/clock_hand_stepper_controller_top_tb.sv
